@@ rtl/slag_pkg.sv @@
package slag_pkg;

  localparam int INDEX_BITS_DEF  = 24;
  localparam int REPEAT_BITS_DEF = 16;
  localparam int IN_DATA_BITS    = 8;
  localparam int CFG_ADDR_BITS   = 3;
  localparam int MODE_BITS       = 2;

  localparam logic [CFG_ADDR_BITS-1:0] REG_START  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOOP   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_END    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_REPEAT = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MODE   = 3'd4;

  localparam logic [MODE_BITS-1:0] MODE_FWD  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REV  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PING = 2'd2;

endpackage

@@ rtl/sample_loop_address_generator.sv @@
// channel  dir  tdata                         tuser            tlast
// in_      in   [0] restart, rest zero        -                -
// out_     out  source_frame, zero padded     [0] frame_valid  last
// cfg_     in   write: cfg_we, cfg_addr, cfg_wdata, no read-back
//
// one transaction in, one result out; a new input can be taken every cycle while the output is not stalled
// results are registered and appear in the cycle after the input, held in a single output register
// the input is taken whenever the output register is empty or being drained
// synchronous active-low reset idles the generator, clears configuration and empties the output
module sample_loop_address_generator #(
  parameter int INDEX_BITS  = slag_pkg::INDEX_BITS_DEF,
  parameter int REPEAT_BITS = slag_pkg::REPEAT_BITS_DEF,
  localparam int OUT_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8,
  localparam int CFG_BITS = (INDEX_BITS > REPEAT_BITS) ? INDEX_BITS : REPEAT_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [slag_pkg::IN_DATA_BITS-1:0]  in_tdata,   // restart
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [OUT_DATA_BITS-1:0]           out_tdata,  // source_frame
  output logic                               out_tuser,  // frame_valid
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [slag_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]                cfg_wdata
);

  logic [INDEX_BITS-1:0]          start_r, loop_r, end_r;
  logic [REPEAT_BITS-1:0]         rpt_r;
  logic [slag_pkg::MODE_BITS-1:0] mode_r;
  logic                           out_valid_r;
  logic                           in_acc;
  logic [INDEX_BITS-1:0]          frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      loop_r  <= '0;
      end_r   <= '0;
      rpt_r   <= '0;
      mode_r  <= slag_pkg::MODE_FWD;
    end else if (cfg_we) begin
      case (cfg_addr)
        slag_pkg::REG_START:  start_r <= cfg_wdata[INDEX_BITS-1:0];
        slag_pkg::REG_LOOP:   loop_r  <= cfg_wdata[INDEX_BITS-1:0];
        slag_pkg::REG_END:    end_r   <= cfg_wdata[INDEX_BITS-1:0];
        slag_pkg::REG_REPEAT: rpt_r   <= cfg_wdata[REPEAT_BITS-1:0];
        slag_pkg::REG_MODE:   mode_r  <= cfg_wdata[slag_pkg::MODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  slag_ctrl #(
    .INDEX_BITS (INDEX_BITS),
    .REPEAT_BITS(REPEAT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_acc),
    .restart  (in_tdata[0]),
    .start_idx(start_r),
    .loop_idx (loop_r),
    .end_idx  (end_r),
    .rpt_cnt  (rpt_r),
    .mode     (mode_r),
    .frame_r  (frame),
    .valid_r  (out_tuser),
    .last_r   (out_tlast)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(frame);

endmodule

@@ rtl/slag_ctrl.sv @@
module slag_ctrl #(
  parameter int INDEX_BITS  = slag_pkg::INDEX_BITS_DEF,
  parameter int REPEAT_BITS = slag_pkg::REPEAT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  logic                           restart,
  input  logic [INDEX_BITS-1:0]          start_idx,
  input  logic [INDEX_BITS-1:0]          loop_idx,
  input  logic [INDEX_BITS-1:0]          end_idx,
  input  logic [REPEAT_BITS-1:0]         rpt_cnt,
  input  logic [slag_pkg::MODE_BITS-1:0] mode,
  output logic [INDEX_BITS-1:0]          frame_r,
  output logic                           valid_r,
  output logic                           last_r
);

  typedef enum logic [1:0] {
    SEG_IDLE,
    SEG_HEAD,
    SEG_BACK,
    SEG_LOOP
  } seg_t;

  seg_t                   seg_r, seg_a, seg_nxt;
  logic [INDEX_BITS-1:0]  pos_r, pos_a, pos_nxt;
  logic [REPEAT_BITS-1:0] rep_r, rep_a, rep_nxt, rep_inc;
  logic                   fwd_r, fwd_a, fwd_nxt, fin_fwd;

  logic                   split_head;
  logic [INDEX_BITS-1:0]  head_lim;
  logic                   region_bad;
  logic                   loop_empty;
  logic                   loops_fwd;
  seg_t                   loops_seg, lh_seg;
  logic [INDEX_BITS-1:0]  loops_pos, lh_pos;
  logic                   lh_fwd;
  logic [INDEX_BITS:0]    pos_inc;
  logic [INDEX_BITS:0]    loop_inc;
  logic                   at_top, at_bottom;

  // decisions that depend on configuration only
  always_comb begin
    split_head = (mode == slag_pkg::MODE_REV) &&
                 ((rpt_cnt == '0) || (loop_idx == start_idx));
    head_lim   = split_head ? loop_idx : end_idx;
    region_bad = (loop_idx < start_idx) || (end_idx < loop_idx);
    loop_empty = end_idx <= loop_idx;
    loops_fwd  = !((mode == slag_pkg::MODE_REV) || (mode == slag_pkg::MODE_PING));
    if ((rpt_cnt == '0) || loop_empty) begin
      loops_seg = SEG_IDLE;
      loops_pos = '0;
    end else begin
      loops_seg = SEG_LOOP;
      loops_pos = loops_fwd ? loop_idx : end_idx;
    end
    // leaving the head
    if (split_head && !loop_empty) begin
      lh_seg = SEG_BACK;
      lh_pos = end_idx;
      lh_fwd = 1'b1;
    end else begin
      lh_seg = loops_seg;
      lh_pos = loops_pos;
      lh_fwd = loops_fwd;
    end
  end

  // state after an optional restart
  always_comb begin
    seg_a = seg_r;
    pos_a = pos_r;
    rep_a = rep_r;
    fwd_a = fwd_r;
    if (restart) begin
      rep_a = '0;
      fwd_a = 1'b1;
      if (region_bad) begin
        seg_a = SEG_IDLE;
        pos_a = '0;
      end else if (start_idx >= head_lim) begin
        seg_a = lh_seg;
        pos_a = lh_pos;
        fwd_a = lh_fwd;
      end else begin
        seg_a = SEG_HEAD;
        pos_a = start_idx;
      end
    end
  end

  // one step of advance
  always_comb begin
    pos_inc   = {1'b0, pos_a} + 1'b1;
    loop_inc  = {1'b0, loop_idx} + 1'b1;
    at_top    = pos_inc >= {1'b0, end_idx};
    at_bottom = {1'b0, pos_a} <= loop_inc;
    rep_inc   = rep_a + 1'b1;
    fin_fwd   = (mode == slag_pkg::MODE_PING) ? !fwd_a : fwd_a;
    seg_nxt   = seg_a;
    pos_nxt   = pos_a;
    rep_nxt   = rep_a;
    fwd_nxt   = fwd_a;
    case (seg_a)
      SEG_HEAD: begin
        if (pos_inc >= {1'b0, head_lim}) begin
          seg_nxt = lh_seg;
          pos_nxt = lh_pos;
          fwd_nxt = lh_fwd;
          rep_nxt = '0;
        end else begin
          pos_nxt = pos_inc[INDEX_BITS-1:0];
        end
      end
      SEG_BACK: begin
        if (at_bottom) begin
          seg_nxt = loops_seg;
          pos_nxt = loops_pos;
          fwd_nxt = loops_fwd;
          rep_nxt = '0;
        end else begin
          pos_nxt = pos_a - 1'b1;
        end
      end
      SEG_LOOP: begin
        if (fwd_a ? at_top : at_bottom) begin
          rep_nxt = rep_inc;
          fwd_nxt = fin_fwd;
          if ((rep_inc == '0) || (rep_inc >= rpt_cnt) || loop_empty) begin
            seg_nxt = SEG_IDLE;
            pos_nxt = '0;
          end else begin
            pos_nxt = fin_fwd ? loop_idx : end_idx;
          end
        end else if (fwd_a) begin
          pos_nxt = pos_inc[INDEX_BITS-1:0];
        end else begin
          pos_nxt = pos_a - 1'b1;
        end
      end
      default: begin
        seg_nxt = SEG_IDLE;
        pos_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_IDLE;
      pos_r <= '0;
      rep_r <= '0;
      fwd_r <= 1'b1;
    end else if (step_en) begin
      seg_r <= seg_nxt;
      pos_r <= pos_nxt;
      rep_r <= rep_nxt;
      fwd_r <= fwd_nxt;
    end
    if (step_en) begin
      if (seg_a == SEG_IDLE) begin
        frame_r <= '0;
        valid_r <= 1'b0;
        last_r  <= 1'b0;
      end else begin
        frame_r <= pos_a;
        valid_r <= 1'b1;
        last_r  <= seg_nxt == SEG_IDLE;
      end
    end
  end

endmodule

@@ rtl/slag_checker.sv @@
module slag_checker #(
  parameter int INDEX_BITS  = slag_pkg::INDEX_BITS_DEF,
  parameter int REPEAT_BITS = slag_pkg::REPEAT_BITS_DEF,
  localparam int OUT_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tuser,
  input logic                     out_tlast
);

  // last only on a real frame
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("last marker on an invalid frame");

  // idle results carry zero data
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("nonzero frame on an invalid result");

  // every input transaction yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("input transaction produced no result");

  // output never blocks the input while drained
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with room in the output stage");

endmodule

bind sample_loop_address_generator slag_checker #(
  .INDEX_BITS (INDEX_BITS),
  .REPEAT_BITS(REPEAT_BITS)
) u_slag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

@@ dv/source_frame_checker.sv @@
`timescale 1ns / 1ps

module source_frame_checker #(
  parameter int IW = slag_pkg::INDEX_BITS_DEF,
  parameter int RW = slag_pkg::REPEAT_BITS_DEF,
  localparam int OUT_W = ((IW + 7) / 8) * 8,
  localparam int CFG_W = (IW > RW) ? IW : RW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [slag_pkg::IN_DATA_BITS-1:0]  in_tdata,   // restart
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [OUT_W-1:0]                   out_tdata,  // source_frame
  input  logic                               out_tuser,  // frame_valid
  input  logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [slag_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_W-1:0]                   cfg_wdata,
  output int                                 fail_count,
  output int                                 in_flight
);
  import slag_pkg::*;

  typedef enum logic [1:0] {SEG_IDLE, SEG_HEAD, SEG_BACK, SEG_LOOP} seg_state_t;

  typedef struct packed {
    logic [IW-1:0] frame;
    logic          valid;
    logic          last;
  } frame_t;

  logic [IW-1:0]        start_idx, loop_idx, end_idx;
  logic [RW-1:0]        rep_count;
  logic [MODE_BITS-1:0] mode;

  seg_state_t    seg;
  logic [IW-1:0] pos;
  logic [RW-1:0] reps_done;
  logic          fwd;

  frame_t frames_due[$];
  int     mismatches = 0;

  assign fail_count = mismatches;

  function automatic bit head_splits();
    return mode == MODE_REV && (rep_count == '0 || loop_idx == start_idx);
  endfunction

  function automatic logic [IW-1:0] head_bound();
    return head_splits() ? loop_idx : end_idx;
  endfunction

  function automatic void open_loops();
    reps_done = '0;
    fwd = !(mode == MODE_REV || mode == MODE_PING);
    if (rep_count == '0 || end_idx <= loop_idx) begin
      seg = SEG_IDLE;
      pos = '0;
    end else begin
      seg = SEG_LOOP;
      pos = fwd ? loop_idx : end_idx;
    end
  endfunction

  function automatic void exit_head();
    if (head_splits() && end_idx > loop_idx) begin
      seg = SEG_BACK;
      pos = end_idx;
    end else begin
      open_loops();
    end
  endfunction

  function automatic void close_repeat();
    reps_done = reps_done + 1'b1;
    if (mode == MODE_PING) fwd = !fwd;
    if (reps_done == '0 || reps_done >= rep_count || end_idx <= loop_idx) begin
      seg = SEG_IDLE;
      pos = '0;
    end else begin
      pos = fwd ? loop_idx : end_idx;
    end
  endfunction

  function automatic void open_render();
    reps_done = '0;
    fwd = 1'b1;
    if (loop_idx < start_idx || end_idx < loop_idx) begin
      seg = SEG_IDLE;
      pos = '0;
    end else begin
      seg = SEG_HEAD;
      pos = start_idx;
      if (pos >= head_bound()) exit_head();
    end
  endfunction

  function automatic void step_position();
    case (seg)
      SEG_HEAD: begin
        if (longint'(pos) + 1 >= longint'(head_bound())) exit_head();
        else pos = pos + 1'b1;
      end
      SEG_BACK: begin
        if (longint'(pos) <= longint'(loop_idx) + 1) open_loops();
        else pos = pos - 1'b1;
      end
      SEG_LOOP: begin
        if (fwd) begin
          if (longint'(pos) + 1 >= longint'(end_idx)) close_repeat();
          else pos = pos + 1'b1;
        end else begin
          if (longint'(pos) <= longint'(loop_idx) + 1) close_repeat();
          else pos = pos - 1'b1;
        end
      end
      default: begin
        seg = SEG_IDLE;
        pos = '0;
      end
    endcase
  endfunction

  function automatic frame_t next_source_frame(input logic restart);
    frame_t f;
    f = '0;
    if (restart) open_render();
    if (seg == SEG_IDLE) return f;
    f.frame = pos;
    f.valid = 1'b1;
    step_position();
    f.last = (seg == SEG_IDLE);
    return f;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_t want;
    frame_t due;
    if (!rst_n) begin
      start_idx = '0;
      loop_idx  = '0;
      end_idx   = '0;
      rep_count = '0;
      mode      = MODE_FWD;
      seg       = SEG_IDLE;
      pos       = '0;
      reps_done = '0;
      fwd       = 1'b1;
      frames_due.delete();
    end else begin
      // a transaction at this edge still sees the old configuration
      if (in_tvalid && in_tready) begin
        due = next_source_frame(in_tdata[0]);
        frames_due = {frames_due, due};
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_START:  start_idx = cfg_wdata[IW-1:0];
          REG_LOOP:   loop_idx  = cfg_wdata[IW-1:0];
          REG_END:    end_idx   = cfg_wdata[IW-1:0];
          REG_REPEAT: rep_count = cfg_wdata[RW-1:0];
          REG_MODE:   mode      = cfg_wdata[MODE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          report("transaction with nothing pending", 64'(out_tdata), 64'(0));
        end else begin
          want = frames_due.pop_front();
          if (out_tdata != OUT_W'(want.frame)) begin
            report("source_frame", 64'(out_tdata), 64'(want.frame));
          end
          if (out_tuser != want.valid) report("frame_valid", 64'(out_tuser), 64'(want.valid));
          if (out_tlast != want.last) report("last", 64'(out_tlast), 64'(want.last));
        end
      end
    end
    in_flight <= frames_due.size();
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import slag_pkg::*;

  localparam int IW          = INDEX_BITS_DEF;
  localparam int RW          = REPEAT_BITS_DEF;
  localparam int OUT_W       = ((IW + 7) / 8) * 8;
  localparam int CFG_W       = (IW > RW) ? IW : RW;
  localparam int ITEM_TARGET = 2000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;

  localparam logic [IW-1:0]        IDX_MAX     = '1;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // restart
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_W-1:0]         out_tdata;  // source_frame
  logic                     out_tuser;  // frame_valid
  logic                     out_tlast;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_W-1:0]         cfg_wdata;

  int fail_count;
  int in_flight;
  int items_sent  = 0;
  int burst_left  = 1;
  int cycle_count = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  sample_loop_address_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  source_frame_checker frame_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = $urandom_range(1, 40);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case ($urandom_range(0, 5))
          0, 1: begin
            out_tready <= 1'b1;
            repeat (n) @(posedge clk);
          end
          2: begin
            out_tready <= 1'b0;
            repeat (n) @(posedge clk);
          end
          default: begin
            repeat (n) begin
              out_tready <= ($urandom_range(0, 2) != 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_region(input logic [IW-1:0] s, input logic [IW-1:0] l,
                            input logic [IW-1:0] e, input logic [RW-1:0] r,
                            input logic [MODE_BITS-1:0] m);
    write_reg(REG_START, CFG_W'(s));
    write_reg(REG_LOOP, CFG_W'(l));
    write_reg(REG_END, CFG_W'(e));
    write_reg(REG_REPEAT, CFG_W'(r));
    write_reg(REG_MODE, CFG_W'(m));
    cfg_we <= 1'b0;
  endtask

  task automatic send_item(input bit restart);
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'(restart);
    do @(posedge clk); while (!in_tready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic end_phase();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic run_render(input int n);
    send_item(1'b1);
    repeat (n - 1) send_item(1'b0);
    end_phase();
  endtask

  task automatic pick_region();
    logic [IW-1:0] base, s, l, e;
    logic [RW-1:0] r;
    int shape;
    shape = $urandom_range(0, 19);
    if (shape < 12) base = IW'($urandom_range(0, 40));
    else if (shape < 15) base = IDX_MAX - IW'(24);
    else base = IW'($urandom_range(0, 32'(IDX_MAX) - 24));
    s = base + IW'($urandom_range(0, 8));
    l = s + IW'($urandom_range(0, 8));
    e = l + IW'($urandom_range(0, 8));
    if (shape == 15 && s != '0) l = s - 1'b1;
    if (shape == 16 && l != '0) e = l - 1'b1;
    if (shape == 17) e = IDX_MAX;
    if (shape == 18) begin
      s = IW'($urandom);
      l = IW'($urandom);
      e = IW'($urandom);
    end
    case ($urandom_range(0, 19))
      0:       r = '1;
      1, 2:    r = RW'($urandom);
      default: r = RW'($urandom_range(0, 4));
    endcase
    if ($urandom_range(0, 6) != 0) begin
      write_reg(REG_START, CFG_W'(s));
      write_reg(REG_LOOP, CFG_W'(l));
      write_reg(REG_END, CFG_W'(e));
    end
    if ($urandom_range(0, 3) != 0) write_reg(REG_REPEAT, CFG_W'(r) | (CFG_W'($urandom) << RW));
    if ($urandom_range(0, 3) != 0) begin
      write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)) | (CFG_W'($urandom) << MODE_BITS));
    end
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_ADDR_BITS'($urandom_range(32'(REG_MODE) + 1, (1 << CFG_ADDR_BITS) - 1)),
                CFG_W'($urandom));
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    bit lead;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = $urandom_range(1, 12);

    // empty render and idle advance straight out of reset
    run_render(2);
    set_region(IDX_MAX - IW'(2), IDX_MAX - IW'(1), IDX_MAX, RW'(1), MODE_PING);
    run_render(4);
    // reversed head with no repeats
    set_region(IW'(0), IW'(2), IW'(4), RW'(0), MODE_REV);
    run_render(6);
    set_region(IW'(5), IW'(5), IW'(7), RW'(1), MODE_UNUSED);
    run_render(5);
    // loop before start
    set_region(IW'(6), IW'(5), IW'(7), RW'(1), MODE_FWD);
    run_render(1);
    set_region(IW'(1), IW'(2), IW'(4), RW'(2), MODE_PING);
    run_render(7);

    // long receiver hold while the sender keeps offering
    hold_req = 1'b1;
    burst_left = 1000;
    run_render(80);
    burst_left = $urandom_range(1, 12);

    while (items_sent < ITEM_TARGET) begin
      pick_region();
      n = $urandom_range(4, 40);
      lead = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < n; i++) send_item(i == 0 ? lead : ($urandom_range(0, 29) == 0));
      end_phase();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
